@@ hw/rtl/spi_adc_sample_reader_top_macros.svh @@
// assertion macros shared by the spi adc sample reader rtl
// expects signals named clock and reset in the including module
`ifndef SPI_ADC_SAMPLE_READER_TOP_MACROS_SVH
`define SPI_ADC_SAMPLE_READER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define SRD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/spiadc_pkg.sv @@
// types and constants for the spi adc sample reader
// used by spiadc_seq and spi_adc_sample_reader_top
package spiadc_pkg;

   localparam int READ_BITS    = 12;
   localparam int COMMAND_BITS = 5;
   localparam int SAMPLE_BITS  = 10;
   localparam int TICK_BITS    = 10;
   localparam int CHANNEL_BITS = 4;
   localparam int INDEX_BITS   = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [COMMAND_BITS-1:0] CMD_PREFIX  = 5'h18;
   localparam logic [CHANNEL_BITS-1:0] MAX_CHANNEL = 4'd7;
   localparam logic [TICK_BITS-1:0]    PHASE_TICKS_RESET = 10'd5;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // word index of the phase_ticks register
   localparam logic REG_PHASE_TICKS = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SEL_HIGH  = 3'd1,
      PH_SEL_LOW   = 3'd2,
      PH_CMD_SETUP = 3'd3,
      PH_CMD_HIGH  = 3'd4,
      PH_GAP       = 3'd5,
      PH_RD_HIGH   = 3'd6,
      PH_RD_LOW    = 3'd7
   } phase_type;

   typedef struct packed {
      logic                    kind;
      logic [CHANNEL_BITS-1:0] channel;
      logic                    miso_level;
   } item_type;

   typedef struct packed {
      logic                   chip_select_n;
      logic                   serial_clock;
      logic                   mosi_level;
      logic                   busy_res;
      logic                   done_res;
      logic                   error;
      logic [SAMPLE_BITS-1:0] sample;
   } result_type;

endpackage

@@ hw/rtl/spiadc_seq.sv @@
// spi read sequencer: phase state machine, command and data shifters, pin levels
// depends on spiadc_pkg
module spiadc_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  spiadc_pkg::item_type              item,
   input  logic [spiadc_pkg::TICK_BITS-1:0]  phase_ticks,
   output spiadc_pkg::result_type            result
);
   import spiadc_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [INDEX_BITS-1:0]   bit_index_ff, bit_index_in;
   logic [COMMAND_BITS-1:0] cmd_ff, cmd_in;
   logic [READ_BITS-1:0]    data_ff, data_in;
   logic [TICK_BITS-1:0]    wait_ff, wait_in;
   logic                    cs_ff, cs_in;
   logic                    sck_ff, sck_in;
   logic                    mosi_ff, mosi_in;

   logic [TICK_BITS-1:0]    wait_inc;
   logic [TICK_BITS-1:0]    limit;
   logic                    wait_hit;
   logic [INDEX_BITS:0]     bit_inc;
   logic                    cmd_last;
   logic                    read_last;
   logic [READ_BITS-1:0]    data_shifted;
   logic                    is_start;
   logic                    is_tick;
   logic                    bad_channel;
   logic                    done_flag;
   logic                    err_flag;
   logic [SAMPLE_BITS-1:0]  sample_val;

   assign is_start     = step && (item.kind == KIND_START);
   assign is_tick      = step && (item.kind == KIND_TICK);
   assign bad_channel  = item.channel > MAX_CHANNEL;
   assign wait_inc     = wait_ff + TICK_BITS'(1);
   // zero ticks behaves as one
   assign limit        = (phase_ticks == '0) ? TICK_BITS'(1) : phase_ticks;
   assign wait_hit     = wait_inc >= limit;
   assign bit_inc      = {1'b0, bit_index_ff} + (INDEX_BITS+1)'(1);
   assign cmd_last     = bit_inc >= (INDEX_BITS+1)'(COMMAND_BITS);
   assign read_last    = bit_inc >= (INDEX_BITS+1)'(READ_BITS);
   assign data_shifted = {data_ff[READ_BITS-2:0], item.miso_level};

   // next state
   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      wait_in      = wait_ff;
      cs_in        = cs_ff;
      sck_in       = sck_ff;
      mosi_in      = mosi_ff;
      if (is_start) begin
         if (phase_ff == PH_IDLE && !bad_channel) begin
            cmd_in       = CMD_PREFIX | COMMAND_BITS'(item.channel);
            bit_index_in = '0;
            data_in      = '0;
            wait_in      = '0;
            cs_in        = 1'b1;
            sck_in       = 1'b0;
            phase_in     = PH_SEL_HIGH;
         end
      end else if (is_tick) begin
         if (phase_ff == PH_GAP) begin
            // single-tick low gap between command and read
            sck_in   = 1'b1;
            wait_in  = '0;
            phase_in = PH_RD_HIGH;
         end else if (phase_ff != PH_IDLE) begin
            wait_in = wait_inc;
            if (wait_hit) begin
               wait_in = '0;
               case (phase_ff)
                  PH_SEL_HIGH: begin
                     cs_in    = 1'b0;
                     phase_in = PH_SEL_LOW;
                  end
                  PH_SEL_LOW: begin
                     mosi_in  = cmd_ff[COMMAND_BITS-1];
                     cmd_in   = {cmd_ff[COMMAND_BITS-2:0], 1'b0};
                     phase_in = PH_CMD_SETUP;
                  end
                  PH_CMD_SETUP: begin
                     sck_in   = 1'b1;
                     phase_in = PH_CMD_HIGH;
                  end
                  PH_CMD_HIGH: begin
                     sck_in = 1'b0;
                     if (!cmd_last) begin
                        bit_index_in = bit_inc[INDEX_BITS-1:0];
                        mosi_in      = cmd_ff[COMMAND_BITS-1];
                        cmd_in       = {cmd_ff[COMMAND_BITS-2:0], 1'b0};
                        phase_in     = PH_CMD_SETUP;
                     end else begin
                        bit_index_in = '0;
                        phase_in     = PH_GAP;
                     end
                  end
                  PH_RD_HIGH: begin
                     sck_in   = 1'b0;
                     phase_in = PH_RD_LOW;
                  end
                  PH_RD_LOW: begin
                     data_in = data_shifted;
                     if (!read_last) begin
                        bit_index_in = bit_inc[INDEX_BITS-1:0];
                        sck_in       = 1'b1;
                        phase_in     = PH_RD_HIGH;
                     end else begin
                        bit_index_in = '0;
                        cs_in        = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end
   end

   // result flags
   always_comb begin
      done_flag  = 1'b0;
      err_flag   = 1'b0;
      sample_val = '0;
      if (is_start && phase_ff == PH_IDLE && bad_channel) begin
         done_flag = 1'b1;
         err_flag  = 1'b1;
      end else if (is_tick && phase_ff == PH_RD_LOW && wait_hit && read_last) begin
         done_flag  = 1'b1;
         // drop the trailing bit, keep the ten after the null bit
         sample_val = data_shifted[READ_BITS-2 -: SAMPLE_BITS];
      end
   end

   always_comb begin
      result.chip_select_n = cs_in;
      result.serial_clock  = sck_in;
      result.mosi_level    = mosi_in;
      result.busy_res      = phase_in != PH_IDLE;
      result.done_res      = done_flag;
      result.error         = err_flag;
      result.sample        = sample_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= '0;
         cmd_ff       <= '0;
         data_ff      <= '0;
         wait_ff      <= '0;
         cs_ff        <= 1'b1;
         sck_ff       <= 1'b0;
         mosi_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         cmd_ff       <= cmd_in;
         data_ff      <= data_in;
         wait_ff      <= wait_in;
         cs_ff        <= cs_in;
         sck_ff       <= sck_in;
         mosi_ff      <= mosi_in;
      end
   end

endmodule

@@ hw/rtl/spi_adc_sample_reader_top.sv @@
// a word accepted on req goes through the input register, then the result register, to rsp
// throughput: one word per cycle while the result side does not stall
// either side may stall; an empty input register takes a word while a result waits
// reset (synchronous, active high): sequencer idle, chip select high, phase_ticks 5
// depends on spiadc_pkg, spiadc_seq and spi_adc_sample_reader_top_macros.svh
`include "spi_adc_sample_reader_top_macros.svh"

module spi_adc_sample_reader_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // channel[3:0], miso_level[4], zero
   input  logic                                req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // chip_select_n[0], serial_clock[1], mosi_level[2], busy_res[3], done_res[4],
   // error[5], sample[15:6]
   output logic [15:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spiadc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [spiadc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [spiadc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import spiadc_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   item_type             in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_result_ff;
   logic [TICK_BITS-1:0] ticks_ff;

   logic                 advance;
   logic                 step;
   logic                 req_take;
   logic                 csr_write;
   logic                 csr_hit;
   result_type           seq_result;

   assign advance     = !out_valid_ff || rsp_tready;
   assign step        = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1] == REG_PHASE_TICKS;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(ticks_ff) : '0;

   spiadc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .phase_ticks (ticks_ff),
      .result      (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ticks_ff     <= PHASE_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            ticks_ff <= csr_pwdata[TICK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind       <= req_tuser;
         in_item_ff.channel    <= req_tdata[CHANNEL_BITS-1:0];
         in_item_ff.miso_level <= req_tdata[CHANNEL_BITS];
      end
      if (step) begin
         out_result_ff <= seq_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_result_ff.sample,
                        out_result_ff.error,
                        out_result_ff.done_res,
                        out_result_ff.busy_res,
                        out_result_ff.mosi_level,
                        out_result_ff.serial_clock,
                        out_result_ff.chip_select_n};

   `SRD_ASSERT_NEXT(a_in_held, in_valid_ff && !advance, in_valid_ff && $stable(in_item_ff), "input word lost while the result side stalls")
   `SRD_ASSERT_NEXT(a_step_fills_out, step, out_valid_ff, "processed word did not reach the result register")
   `SRD_ASSERT_SAME(a_idle_deselects, step && !seq_result.busy_res, seq_result.chip_select_n, "chip select low while the sequencer is idle")
   `SRD_ASSERT_SAME(a_error_is_done, step && seq_result.error, seq_result.done_res && seq_result.sample == '0, "error result without done or with a sample")

endmodule

@@ dv/spi_adc_sample_reader_top_tb.sv @@
// self-checking testbench for spi_adc_sample_reader_top: drives start and tick words,
// predicts the pin levels, flags and sample of every result word and compares them
// depends on spiadc_pkg and the rtl of spi_adc_sample_reader_top
module spi_adc_sample_reader_top_tb;
   import spiadc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_ADDR_W-1:0] PHASE_TICKS_ADDR =
      CSR_ADDR_W'({REG_PHASE_TICKS, 2'b00});

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // channel[3:0], miso_level[4], zero
   logic                  req_tuser;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // chip_select_n[0], serial_clock[1], mosi_level[2], busy_res[3], done_res[4],
   // error[5], sample[15:6]
   logic [15:0]           rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spi_adc_sample_reader_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // sequencer copy used for prediction
   logic [TICK_BITS-1:0]    ticks_cfg;
   phase_type               seq_phase;
   logic [INDEX_BITS-1:0]   seq_bit;
   logic [COMMAND_BITS-1:0] cmd_bits;
   logic [READ_BITS-1:0]    rx_bits;
   logic [TICK_BITS-1:0]    tick_count;
   logic                    cs_n;
   logic                    sck;
   logic                    mosi;

   result_type expected_pins[$];

   int fail_count;
   int words_sent;
   int samples_read;
   int channel_rejects;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_pins.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic result_type advance_sequencer(input logic kind,
                                                    input logic [CHANNEL_BITS-1:0] chan,
                                                    input logic miso);
      result_type           r;
      logic [TICK_BITS-1:0] lim;
      r = '0;
      lim = (ticks_cfg == '0) ? TICK_BITS'(1) : ticks_cfg;
      if (kind == KIND_START) begin
         if (seq_phase == PH_IDLE) begin
            if (chan > MAX_CHANNEL) begin
               r.done_res = 1'b1;
               r.error    = 1'b1;
            end else begin
               cmd_bits   = CMD_PREFIX | COMMAND_BITS'(chan);
               seq_bit    = '0;
               rx_bits    = '0;
               tick_count = '0;
               cs_n       = 1'b1;
               sck        = 1'b0;
               seq_phase  = PH_SEL_HIGH;
            end
         end
      end else if (seq_phase == PH_GAP) begin
         // the clock stays low for a single tick between command and read
         sck        = 1'b1;
         tick_count = '0;
         seq_phase  = PH_RD_HIGH;
      end else if (seq_phase != PH_IDLE) begin
         tick_count = tick_count + 1'b1;
         if (tick_count >= lim) begin
            tick_count = '0;
            case (seq_phase)
               PH_SEL_HIGH: begin
                  cs_n      = 1'b0;
                  seq_phase = PH_SEL_LOW;
               end
               PH_SEL_LOW: begin
                  mosi      = cmd_bits[COMMAND_BITS-1];
                  cmd_bits  = cmd_bits << 1;
                  seq_phase = PH_CMD_SETUP;
               end
               PH_CMD_SETUP: begin
                  sck       = 1'b1;
                  seq_phase = PH_CMD_HIGH;
               end
               PH_CMD_HIGH: begin
                  sck = 1'b0;
                  if (int'(seq_bit) + 1 < COMMAND_BITS) begin
                     seq_bit   = seq_bit + 1'b1;
                     mosi      = cmd_bits[COMMAND_BITS-1];
                     cmd_bits  = cmd_bits << 1;
                     seq_phase = PH_CMD_SETUP;
                  end else begin
                     seq_bit   = '0;
                     seq_phase = PH_GAP;
                  end
               end
               PH_RD_HIGH: begin
                  sck       = 1'b0;
                  seq_phase = PH_RD_LOW;
               end
               default: begin
                  rx_bits = {rx_bits[READ_BITS-2:0], miso};
                  if (int'(seq_bit) + 1 < READ_BITS) begin
                     seq_bit   = seq_bit + 1'b1;
                     sck       = 1'b1;
                     seq_phase = PH_RD_HIGH;
                  end else begin
                     seq_bit    = '0;
                     cs_n       = 1'b1;
                     seq_phase  = PH_IDLE;
                     r.done_res = 1'b1;
                     // leading null bit and trailing bit dropped
                     r.sample   = SAMPLE_BITS'(rx_bits >> (READ_BITS - 11));
                  end
               end
            endcase
         end
      end
      r.chip_select_n = cs_n;
      r.serial_clock  = sck;
      r.mosi_level    = mosi;
      r.busy_res      = (seq_phase != PH_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pins.size() == 0) begin
            $error("rsp word %h with nothing expected", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_pins.pop_front();
            check_field("chip_select_n", want.chip_select_n, rsp_tdata[0]);
            check_field("serial_clock", want.serial_clock, rsp_tdata[1]);
            check_field("mosi_level", want.mosi_level, rsp_tdata[2]);
            check_field("busy_res", want.busy_res, rsp_tdata[3]);
            check_field("done_res", want.done_res, rsp_tdata[4]);
            check_field("error", want.error, rsp_tdata[5]);
            check_field("sample", want.sample, rsp_tdata[15:6]);
            if (want.done_res && !want.error) samples_read++;
            if (want.error) channel_rejects++;
         end
      end
   end

   // receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_word(input logic kind, input logic [CHANNEL_BITS-1:0] chan,
                            input logic miso);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, miso, chan};
      do @(posedge clock); while (!req_tready);
      expected_pins.push_back(advance_sequencer(kind, chan, miso));
      words_sent++;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read(output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= PHASE_TICKS_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_phase_ticks(input logic [TICK_BITS-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      wait_drained();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PHASE_TICKS_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ticks_cfg = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read(readback);
      check_field("phase_ticks readback", value, readback[TICK_BITS-1:0]);
   endtask

   task automatic finish_read;
      while (seq_phase != PH_IDLE)
         send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
   endtask

   // miso_mode: 0 all low, 1 all high, 2 random, 3 alternating
   task automatic run_read(input logic [CHANNEL_BITS-1:0] chan, input int miso_mode);
      logic m;
      send_word(KIND_START, chan, 1'b0);
      while (seq_phase != PH_IDLE) begin
         case (miso_mode)
            0:       m = 1'b0;
            1:       m = 1'b1;
            3:       m = words_sent[0];
            default: m = 1'($urandom_range(1));
         endcase
         send_word(KIND_TICK, 4'($urandom_range(15)), m);
      end
   endtask

   task automatic test_reset_values;
      logic [CSR_DATA_W-1:0] value;
      csr_read(value);
      check_field("phase_ticks after reset", PHASE_TICKS_RESET, value[TICK_BITS-1:0]);
      // idle ticks change nothing, out-of-range channels are rejected at once
      send_word(KIND_TICK, 4'h0, 1'b0);
      send_word(KIND_TICK, 4'hF, 1'b1);
      for (int c = 8; c <= 15; c++) send_word(KIND_START, c[3:0], c[0]);
      wait_drained();
   endtask

   task automatic test_directed_reads;
      run_read(4'd3, 2);
      set_phase_ticks(TICK_BITS'(1));
      run_read(4'd0, 1);
      run_read(4'd7, 0);
      // starts in the middle of a read are dropped, bad channel included
      send_word(KIND_START, 4'd5, 1'b0);
      repeat (10) send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
      send_word(KIND_START, 4'hC, 1'b1);
      send_word(KIND_START, 4'd2, 1'b0);
      finish_read();
      set_phase_ticks(TICK_BITS'(0));
      run_read(4'd6, 3);
      // longest phase, then shorten it while the tick count is well past the new limit
      set_phase_ticks('1);
      send_word(KIND_START, 4'd1, 1'b0);
      repeat (30) send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
      set_phase_ticks(TICK_BITS'(1));
      finish_read();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input logic [TICK_BITS-1:0] ticks, input int count);
      int sent;
      int pick;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      set_phase_ticks(ticks);
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (seq_phase == PH_IDLE) begin
            if (pick < 8)
               send_word(KIND_START, 4'($urandom_range(15, 8)), 1'($urandom_range(1)));
            else if (pick < 14)
               send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
            else
               send_word(KIND_START, 4'($urandom_range(7)), 1'($urandom_range(1)));
         end else if (pick < 4) begin
            send_word(KIND_START, 4'($urandom_range(15)), 1'($urandom_range(1)));
         end else begin
            send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
         end
         sent++;
      end
      finish_read();
      wait_drained();
   endtask

   task automatic test_backpressure;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_phase_ticks(TICK_BITS'(1));
      @(posedge clock);
      hold_left = 300;
      // the sender keeps offering while rsp is held, so req must stall
      send_word(KIND_START, 4'($urandom_range(7)), 1'b0);
      repeat (40) send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
      finish_read();
      wait_drained();
   endtask

   task automatic test_drain_pause;
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      send_word(KIND_START, 4'($urandom_range(7)), 1'b0);
      repeat (20) send_word(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
      // sender goes quiet mid-read until every word is back
      wait_drained();
      finish_read();
      wait_drained();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = KIND_TICK;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      fail_count      = 0;
      words_sent      = 0;
      samples_read    = 0;
      channel_rejects = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_left       = 0;
      ticks_cfg  = PHASE_TICKS_RESET;
      seq_phase  = PH_IDLE;
      seq_bit    = '0;
      cmd_bits   = '0;
      rx_bits    = '0;
      tick_count = '0;
      cs_n       = 1'b1;
      sck        = 1'b0;
      mosi       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_reads();
      test_random_traffic(0, 0, TICK_BITS'(1), 250);
      test_random_traffic(47, 0, TICK_BITS'(2), 250);
      test_random_traffic(0, 47, TICK_BITS'($urandom_range(4, 1)), 250);
      test_random_traffic(15, 15, TICK_BITS'(0), 250);
      test_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d words: %0d samples read, %0d out-of-range channel starts",
               words_sent, samples_read, channel_rejects);
      $display("phase_ticks swept over 0, 1, 2, 5 and 1023 under four idle/stall mixes");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
